[rtl/dgrs_pkg.sv]
// shared constants and types of the grid ray stepper
package dgrs_pkg;

    localparam int CELL_BITS = 8;
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 24;
    localparam int DELTA_W   = 24;
    localparam int DIST_W    = 32;
    localparam int OFF_W     = POS_W + 1;
    localparam int PROD_W    = OFF_W + DELTA_W;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } t_func;

    typedef enum logic {
        SIDE_X = 1'b0,
        SIDE_Y = 1'b1
    } t_side;

    typedef struct packed {
        t_func                func;
        logic [CELL_BITS-1:0] cell_x;
        logic [CELL_BITS-1:0] cell_y;
        logic                 neg_x;
        logic                 neg_y;
        logic [DELTA_W-1:0]   delta_x;
        logic [DELTA_W-1:0]   delta_y;
        logic [DIST_W-1:0]    side_x;
        logic [DIST_W-1:0]    side_y;
    } t_cmd;

    typedef struct packed {
        logic [CELL_BITS-1:0] cell_x;
        logic [CELL_BITS-1:0] cell_y;
        t_side                side;
        logic [DIST_W-1:0]    wall;
        logic                 left_map;
    } t_res;

endpackage

[rtl/dda_grid_ray_stepper_top.sv]
// top level of the grid ray stepper: front end, command queue and back end
//
//  channel  handshake        payload
//  input    i_push / o_full  i_func, i_pos_x/y, i_start_cell_x/y, i_dir_x/y_negative,
//                            i_delta_x/y
//  result   o_empty / i_pop  o_cell_x/y, o_crossed_side, o_perp_dist, o_left_map
//
//  one word per cycle sustained while the result side pops; a word is registered in the input
//  stage, then passes the multiply into the queue and the step into the output register
//  the rate is set by the back end's single compare and saturating add per cycle
//  synchronous reset clears the queue, the ray state and the output valid flag
//  a stalled result side fills the queue; full rises once it and the input stage are full
module dda_grid_ray_stepper_top #(
    parameter int Q_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_func,
    input  logic [dgrs_pkg::POS_W-1:0]     i_pos_x,
    input  logic [dgrs_pkg::POS_W-1:0]     i_pos_y,
    input  logic [dgrs_pkg::CELL_BITS-1:0] i_start_cell_x,
    input  logic [dgrs_pkg::CELL_BITS-1:0] i_start_cell_y,
    input  logic                           i_dir_x_negative,
    input  logic                           i_dir_y_negative,
    input  logic [dgrs_pkg::DELTA_W-1:0]   i_delta_x,
    input  logic [dgrs_pkg::DELTA_W-1:0]   i_delta_y,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [dgrs_pkg::CELL_BITS-1:0] o_cell_x,
    output logic [dgrs_pkg::CELL_BITS-1:0] o_cell_y,
    output logic                           o_crossed_side,
    output logic [dgrs_pkg::DIST_W-1:0]    o_perp_dist,
    output logic                           o_left_map
);

    localparam int CMD_W = $bits(dgrs_pkg::t_cmd);

    dgrs_pkg::t_cmd front_cmd;
    dgrs_pkg::t_cmd q_cmd;
    logic           front_push;
    logic           q_full;
    logic           q_empty;
    logic           back_pop;
    dgrs_pkg::t_res res;
    logic           res_valid;

    dgrs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_func           (i_func),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_start_cell_x   (i_start_cell_x),
        .i_start_cell_y   (i_start_cell_y),
        .i_dir_x_negative (i_dir_x_negative),
        .i_dir_y_negative (i_dir_y_negative),
        .i_delta_x        (i_delta_x),
        .i_delta_y        (i_delta_y),
        .o_cmd_push       (front_push),
        .o_cmd            (front_cmd),
        .i_cmd_full       (q_full)
    );

    dgrs_fifo #(
        .W     (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    dgrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (back_pop),
        .i_pop       (i_pop),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    assign o_empty        = !res_valid;
    assign o_cell_x       = res.cell_x;
    assign o_cell_y       = res.cell_y;
    assign o_crossed_side = res.side;
    assign o_perp_dist    = res.wall;
    assign o_left_map     = res.left_map;

endmodule

[rtl/dgrs_fifo.sv]
// small first-in first-out queue between the front and the back
module dgrs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/dgrs_front.sv]
// front end: accepts words, computes initial side distances for start words
module dgrs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_func,
    input  logic [dgrs_pkg::POS_W-1:0]     i_pos_x,
    input  logic [dgrs_pkg::POS_W-1:0]     i_pos_y,
    input  logic [dgrs_pkg::CELL_BITS-1:0] i_start_cell_x,
    input  logic [dgrs_pkg::CELL_BITS-1:0] i_start_cell_y,
    input  logic                           i_dir_x_negative,
    input  logic                           i_dir_y_negative,
    input  logic [dgrs_pkg::DELTA_W-1:0]   i_delta_x,
    input  logic [dgrs_pkg::DELTA_W-1:0]   i_delta_y,
    output logic                           o_cmd_push,
    output dgrs_pkg::t_cmd                 o_cmd,
    input  logic                           i_cmd_full
);

    localparam int SH_W = dgrs_pkg::PROD_W - dgrs_pkg::FRAC_BITS;

    function automatic logic [dgrs_pkg::OFF_W-1:0] boundary_offset(
        input logic [dgrs_pkg::POS_W-1:0]     pos,
        input logic [dgrs_pkg::CELL_BITS-1:0] grid,
        input logic                           neg
    );
        logic [dgrs_pkg::OFF_W-1:0] p;
        logic [dgrs_pkg::OFF_W-1:0] lo;
        logic [dgrs_pkg::OFF_W-1:0] hi;
        logic [dgrs_pkg::OFF_W-1:0] res;
        p   = dgrs_pkg::OFF_W'(pos);
        lo  = dgrs_pkg::OFF_W'({grid, {dgrs_pkg::FRAC_BITS{1'b0}}});
        hi  = lo + (dgrs_pkg::OFF_W'(1) << dgrs_pkg::FRAC_BITS);
        if (neg) begin
            res = (p >= lo) ? p - lo : '0;
        end else begin
            res = (hi >= p) ? hi - p : '0;
        end
        return res;
    endfunction

    function automatic logic [dgrs_pkg::DIST_W-1:0] sat_mul(
        input logic [dgrs_pkg::OFF_W-1:0]   off,
        input logic [dgrs_pkg::DELTA_W-1:0] delta
    );
        logic [dgrs_pkg::PROD_W-1:0] prod;
        logic [SH_W-1:0]             sh;
        prod = dgrs_pkg::PROD_W'(off) * dgrs_pkg::PROD_W'(delta);
        sh   = prod[dgrs_pkg::PROD_W-1:dgrs_pkg::FRAC_BITS];
        return (|sh[SH_W-1:dgrs_pkg::DIST_W]) ? '1 : sh[dgrs_pkg::DIST_W-1:0];
    endfunction

    logic                           r_valid, n_valid;
    dgrs_pkg::t_func                r_func;
    logic [dgrs_pkg::OFF_W-1:0]     r_off_x;
    logic [dgrs_pkg::OFF_W-1:0]     r_off_y;
    logic [dgrs_pkg::CELL_BITS-1:0] r_cell_x;
    logic [dgrs_pkg::CELL_BITS-1:0] r_cell_y;
    logic                           r_neg_x;
    logic                           r_neg_y;
    logic [dgrs_pkg::DELTA_W-1:0]   r_delta_x;
    logic [dgrs_pkg::DELTA_W-1:0]   r_delta_y;
    logic                           advance;
    logic                           accept;

    assign advance    = r_valid && !i_cmd_full;
    assign o_full     = r_valid && i_cmd_full;
    assign accept     = i_push && !o_full;
    assign o_cmd_push = advance;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= dgrs_pkg::t_func'(i_func);
            r_off_x   <= boundary_offset(i_pos_x, i_start_cell_x, i_dir_x_negative);
            r_off_y   <= boundary_offset(i_pos_y, i_start_cell_y, i_dir_y_negative);
            r_cell_x  <= i_start_cell_x;
            r_cell_y  <= i_start_cell_y;
            r_neg_x   <= i_dir_x_negative;
            r_neg_y   <= i_dir_y_negative;
            r_delta_x <= i_delta_x;
            r_delta_y <= i_delta_y;
        end
    end

    always_comb begin
        o_cmd.func    = r_func;
        o_cmd.cell_x  = r_cell_x;
        o_cmd.cell_y  = r_cell_y;
        o_cmd.neg_x   = r_neg_x;
        o_cmd.neg_y   = r_neg_y;
        o_cmd.delta_x = r_delta_x;
        o_cmd.delta_y = r_delta_y;
        o_cmd.side_x  = sat_mul(r_off_x, r_delta_x);
        o_cmd.side_y  = sat_mul(r_off_y, r_delta_y);
    end

endmodule

[rtl/dgrs_back.sv]
// back end: holds the ray state, loads it on a start word, takes one grid step per step word, registers the result
module dgrs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dgrs_pkg::t_cmd i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output dgrs_pkg::t_res o_res,
    output logic           o_res_valid
);

    logic [dgrs_pkg::DIST_W-1:0]    r_side_x, n_side_x;
    logic [dgrs_pkg::DIST_W-1:0]    r_side_y, n_side_y;
    logic [dgrs_pkg::DELTA_W-1:0]   r_delta_x, n_delta_x;
    logic [dgrs_pkg::DELTA_W-1:0]   r_delta_y, n_delta_y;
    logic [dgrs_pkg::CELL_BITS-1:0] r_cell_x, n_cell_x;
    logic [dgrs_pkg::CELL_BITS-1:0] r_cell_y, n_cell_y;
    logic                           r_neg_x, n_neg_x;
    logic                           r_neg_y, n_neg_y;
    logic                           r_out_valid, n_out_valid;
    dgrs_pkg::t_res                 r_res, n_res;
    logic                           take;
    logic [dgrs_pkg::DIST_W:0]      sum_x;
    logic [dgrs_pkg::DIST_W:0]      sum_y;

    assign take        = !i_cmd_empty && (!r_out_valid || i_pop);
    assign o_cmd_pop   = take;
    assign o_res       = r_res;
    assign o_res_valid = r_out_valid;

    assign sum_x = {1'b0, r_side_x} + (dgrs_pkg::DIST_W + 1)'(r_delta_x);
    assign sum_y = {1'b0, r_side_y} + (dgrs_pkg::DIST_W + 1)'(r_delta_y);

    always_comb begin
        n_side_x    = r_side_x;
        n_side_y    = r_side_y;
        n_delta_x   = r_delta_x;
        n_delta_y   = r_delta_y;
        n_cell_x    = r_cell_x;
        n_cell_y    = r_cell_y;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (take) begin
            n_out_valid    = 1'b1;
            n_res.wall     = '0;
            n_res.left_map = 1'b0;
            n_res.side     = dgrs_pkg::SIDE_X;
            if (i_cmd.func == dgrs_pkg::FUNC_START) begin
                n_side_x  = i_cmd.side_x;
                n_side_y  = i_cmd.side_y;
                n_delta_x = i_cmd.delta_x;
                n_delta_y = i_cmd.delta_y;
                n_cell_x  = i_cmd.cell_x;
                n_cell_y  = i_cmd.cell_y;
                n_neg_x   = i_cmd.neg_x;
                n_neg_y   = i_cmd.neg_y;
            end else if (r_side_x < r_side_y) begin
                n_res.wall = r_side_x;
                n_side_x   = sum_x[dgrs_pkg::DIST_W] ? '1 : sum_x[dgrs_pkg::DIST_W-1:0];
                if (r_neg_x) begin
                    if (r_cell_x == '0) begin
                        n_res.left_map = 1'b1;
                    end else begin
                        n_cell_x = r_cell_x - dgrs_pkg::CELL_BITS'(1);
                    end
                end else begin
                    if (r_cell_x == '1) begin
                        n_res.left_map = 1'b1;
                    end else begin
                        n_cell_x = r_cell_x + dgrs_pkg::CELL_BITS'(1);
                    end
                end
            end else begin
                n_res.wall = r_side_y;
                n_res.side = dgrs_pkg::SIDE_Y;
                n_side_y   = sum_y[dgrs_pkg::DIST_W] ? '1 : sum_y[dgrs_pkg::DIST_W-1:0];
                if (r_neg_y) begin
                    if (r_cell_y == '0) begin
                        n_res.left_map = 1'b1;
                    end else begin
                        n_cell_y = r_cell_y - dgrs_pkg::CELL_BITS'(1);
                    end
                end else begin
                    if (r_cell_y == '1) begin
                        n_res.left_map = 1'b1;
                    end else begin
                        n_cell_y = r_cell_y + dgrs_pkg::CELL_BITS'(1);
                    end
                end
            end
            n_res.cell_x = n_cell_x;
            n_res.cell_y = n_cell_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_x    <= '0;
            r_side_y    <= '0;
            r_delta_x   <= '0;
            r_delta_y   <= '0;
            r_cell_x    <= '0;
            r_cell_y    <= '0;
            r_neg_x     <= 1'b0;
            r_neg_y     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_side_x    <= n_side_x;
            r_side_y    <= n_side_y;
            r_delta_x   <= n_delta_x;
            r_delta_y   <= n_delta_y;
            r_cell_x    <= n_cell_x;
            r_cell_y    <= n_cell_y;
            r_neg_x     <= n_neg_x;
            r_neg_y     <= n_neg_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

[test/dda_grid_ray_stepper_top_tb.sv]
// self-checking testbench of the grid ray stepper: random ray walks against a cell-stepping predictor
module dda_grid_ray_stepper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_BITS    = dgrs_pkg::CELL_BITS;
    localparam int FRAC_BITS    = dgrs_pkg::FRAC_BITS;
    localparam int POS_W        = dgrs_pkg::POS_W;
    localparam int DELTA_W      = dgrs_pkg::DELTA_W;
    localparam int DIST_W       = dgrs_pkg::DIST_W;
    localparam int RANDOM_WORDS = 1200;
    localparam int IDLE_PCT     = 33;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 600;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct {
        dgrs_pkg::t_func      func;
        logic [POS_W-1:0]     pos_x;
        logic [POS_W-1:0]     pos_y;
        logic [CELL_BITS-1:0] cell_x;
        logic [CELL_BITS-1:0] cell_y;
        logic                 neg_x;
        logic                 neg_y;
        logic [DELTA_W-1:0]   delta_x;
        logic [DELTA_W-1:0]   delta_y;
    } t_ray_word;

    typedef struct {
        logic [CELL_BITS-1:0] cell_x;
        logic [CELL_BITS-1:0] cell_y;
        dgrs_pkg::t_side      side;
        logic [DIST_W-1:0]    wall;
        logic                 left_map;
    } t_ray_hit;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_push = 1'b0;
    logic                 o_full;
    logic                 i_func = 1'b0;
    logic [POS_W-1:0]     i_pos_x = '0;
    logic [POS_W-1:0]     i_pos_y = '0;
    logic [CELL_BITS-1:0] i_start_cell_x = '0;
    logic [CELL_BITS-1:0] i_start_cell_y = '0;
    logic                 i_dir_x_negative = 1'b0;
    logic                 i_dir_y_negative = 1'b0;
    logic [DELTA_W-1:0]   i_delta_x = '0;
    logic [DELTA_W-1:0]   i_delta_y = '0;
    logic                 o_empty;
    logic                 i_pop = 1'b0;
    logic [CELL_BITS-1:0] o_cell_x;
    logic [CELL_BITS-1:0] o_cell_y;
    logic                 o_crossed_side;
    logic [DIST_W-1:0]    o_perp_dist;
    logic                 o_left_map;

    dda_grid_ray_stepper_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_func           (i_func),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_start_cell_x   (i_start_cell_x),
        .i_start_cell_y   (i_start_cell_y),
        .i_dir_x_negative (i_dir_x_negative),
        .i_dir_y_negative (i_dir_y_negative),
        .i_delta_x        (i_delta_x),
        .i_delta_y        (i_delta_y),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_cell_x         (o_cell_x),
        .o_cell_y         (o_cell_y),
        .o_crossed_side   (o_crossed_side),
        .o_perp_dist      (o_perp_dist),
        .o_left_map       (o_left_map)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    t_ray_word ray_words[$];
    t_ray_hit  expected_hits[$];

    // predicted ray state
    logic [DIST_W-1:0]    ray_side_x;
    logic [DIST_W-1:0]    ray_side_y;
    logic [DELTA_W-1:0]   ray_delta_x;
    logic [DELTA_W-1:0]   ray_delta_y;
    logic [CELL_BITS-1:0] ray_cell_x;
    logic [CELL_BITS-1:0] ray_cell_y;
    logic                 ray_neg_x;
    logic                 ray_neg_y;
    dgrs_pkg::t_side      ray_last_side;

    int  words_sent;
    int  words_seen;
    int  errors = 0;
    int  hold_left;
    bit  hold_done;
    bit  hold_active;
    int  idle_cycles;

    function automatic logic [DIST_W-1:0] initial_side(logic [POS_W-1:0] pos,
                                                       logic [CELL_BITS-1:0] grid,
                                                       logic neg, logic [DELTA_W-1:0] delta);
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] off;
        logic [63:0] prod;
        low  = 64'(grid) << FRAC_BITS;
        high = (64'(grid) + 64'd1) << FRAC_BITS;
        if (neg) begin
            off = (64'(pos) >= low) ? 64'(pos) - low : 64'd0;
        end else begin
            off = (high >= 64'(pos)) ? high - 64'(pos) : 64'd0;
        end
        prod = (off * 64'(delta)) >> FRAC_BITS;
        return (prod > 64'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] sat_sum(logic [DIST_W-1:0] a, logic [DELTA_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + (DIST_W + 1)'(b);
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    task automatic walk_ray(input t_ray_word w);
        t_ray_hit r;
        r.wall     = '0;
        r.left_map = 1'b0;
        if (w.func == dgrs_pkg::FUNC_START) begin
            ray_cell_x    = w.cell_x;
            ray_cell_y    = w.cell_y;
            ray_neg_x     = w.neg_x;
            ray_neg_y     = w.neg_y;
            ray_delta_x   = w.delta_x;
            ray_delta_y   = w.delta_y;
            ray_side_x    = initial_side(w.pos_x, w.cell_x, w.neg_x, w.delta_x);
            ray_side_y    = initial_side(w.pos_y, w.cell_y, w.neg_y, w.delta_y);
            ray_last_side = dgrs_pkg::SIDE_X;
        end else if (ray_side_x < ray_side_y) begin
            r.wall     = ray_side_x;
            ray_side_x = sat_sum(ray_side_x, ray_delta_x);
            if (ray_neg_x ? (ray_cell_x == '0) : (ray_cell_x == '1)) begin
                r.left_map = 1'b1;
            end else begin
                ray_cell_x = ray_neg_x ? ray_cell_x - CELL_BITS'(1) : ray_cell_x + CELL_BITS'(1);
            end
            ray_last_side = dgrs_pkg::SIDE_X;
        end else begin
            r.wall     = ray_side_y;
            ray_side_y = sat_sum(ray_side_y, ray_delta_y);
            if (ray_neg_y ? (ray_cell_y == '0) : (ray_cell_y == '1)) begin
                r.left_map = 1'b1;
            end else begin
                ray_cell_y = ray_neg_y ? ray_cell_y - CELL_BITS'(1) : ray_cell_y + CELL_BITS'(1);
            end
            ray_last_side = dgrs_pkg::SIDE_Y;
        end
        r.cell_x = ray_cell_x;
        r.cell_y = ray_cell_y;
        r.side   = ray_last_side;
        expected_hits.push_back(r);
    endtask

    function automatic t_ray_word start_word(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                             logic [CELL_BITS-1:0] cx, logic [CELL_BITS-1:0] cy,
                                             logic nx, logic ny,
                                             logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy);
        t_ray_word w;
        w.func    = dgrs_pkg::FUNC_START;
        w.pos_x   = px;
        w.pos_y   = py;
        w.cell_x  = cx;
        w.cell_y  = cy;
        w.neg_x   = nx;
        w.neg_y   = ny;
        w.delta_x = dx;
        w.delta_y = dy;
        return w;
    endfunction

    // fields other than func carry junk on a step
    function automatic t_ray_word step_word();
        t_ray_word w;
        w         = start_word(POS_W'($urandom), POS_W'($urandom),
                               CELL_BITS'($urandom), CELL_BITS'($urandom),
                               1'($urandom), 1'($urandom),
                               DELTA_W'($urandom), DELTA_W'($urandom));
        w.func    = dgrs_pkg::FUNC_STEP;
        return w;
    endfunction

    function automatic logic [CELL_BITS-1:0] pick_cell();
        logic [CELL_BITS-1:0] edges[4];
        edges = '{8'd0, 8'd1, 8'd254, 8'd255};
        if ($urandom_range(99) < 30) begin
            return edges[2'($urandom_range(3))];
        end
        return CELL_BITS'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(logic [CELL_BITS-1:0] grid);
        int pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            return {grid, 16'($urandom)};
        end else if (pick < 90) begin
            return {grid, 16'h0000};
        end
        return POS_W'($urandom);
    endfunction

    function automatic logic [DELTA_W-1:0] pick_delta();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DELTA_W'($urandom_range(24'h03FFFF));
            5, 6:    return DELTA_W'($urandom_range(24'h00FFFF)) + DELTA_W'(1);
            default: return DELTA_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("word %0d %s: got %0h, want %0h", words_seen, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push        <= 1'b0;
            words_sent    = 0;
            ray_side_x    = '0;
            ray_side_y    = '0;
            ray_delta_x   = '0;
            ray_delta_y   = '0;
            ray_cell_x    = '0;
            ray_cell_y    = '0;
            ray_neg_x     = 1'b0;
            ray_neg_y     = 1'b0;
            ray_last_side = dgrs_pkg::SIDE_X;
        end else begin
            if (i_push && !o_full) begin
                walk_ray(ray_words.pop_front());
                words_sent++;
            end
            if (i_push && o_full) begin
                // hold the word until taken
            end else if (ray_words.size() != 0 &&
                         (hold_active || (words_sent >= CALM_FROM && words_sent < CALM_TO) ||
                          $urandom_range(99) >= IDLE_PCT)) begin
                i_push           <= 1'b1;
                i_func           <= ray_words[0].func;
                i_pos_x          <= ray_words[0].pos_x;
                i_pos_y          <= ray_words[0].pos_y;
                i_start_cell_x   <= ray_words[0].cell_x;
                i_start_cell_y   <= ray_words[0].cell_y;
                i_dir_x_negative <= ray_words[0].neg_x;
                i_dir_y_negative <= ray_words[0].neg_y;
                i_delta_x        <= ray_words[0].delta_x;
                i_delta_y        <= ray_words[0].delta_y;
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop       <= 1'b0;
            hold_active <= 1'b0;
            words_seen  = 0;
            hold_left   = 0;
            hold_done   = 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected word", o_perp_dist, 0);
                end else begin
                    if (o_cell_x !== expected_hits[0].cell_x)
                        report_mismatch("cell_x", o_cell_x, expected_hits[0].cell_x);
                    if (o_cell_y !== expected_hits[0].cell_y)
                        report_mismatch("cell_y", o_cell_y, expected_hits[0].cell_y);
                    if (o_crossed_side !== expected_hits[0].side)
                        report_mismatch("crossed_side", o_crossed_side, expected_hits[0].side);
                    if (o_perp_dist !== expected_hits[0].wall)
                        report_mismatch("perp_dist", o_perp_dist, expected_hits[0].wall);
                    if (o_left_map !== expected_hits[0].left_map)
                        report_mismatch("left_map", o_left_map, expected_hits[0].left_map);
                    void'(expected_hits.pop_front());
                end
                words_seen++;
            end
            if (words_seen == HOLD_AT && !hold_done) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_pop       <= 1'b0;
                hold_active <= 1'b1;
            end else begin
                hold_active <= 1'b0;
                i_pop       <= (words_seen >= CALM_FROM && words_seen < CALM_TO) ||
                               ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("dda_grid_ray_stepper_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n_steps;
        t_ray_word w;
        logic [CELL_BITS-1:0] cx;
        logic [CELL_BITS-1:0] cy;

        // steps from the reset state tie and go along y
        ray_words.push_back(step_word());
        ray_words.push_back(step_word());
        // at the low corner heading down: zero side distances, both axes leave the map
        ray_words.push_back(start_word(24'h000000, 24'h000000, 8'd0, 8'd0, 1'b1, 1'b1,
                                       24'h010000, 24'h010000));
        ray_words.push_back(step_word());
        ray_words.push_back(step_word());
        // at the high corner with infinite deltas: accumulators saturate
        ray_words.push_back(start_word(24'h000000, 24'h000000, 8'd255, 8'd255, 1'b0, 1'b0,
                                       24'hFFFFFF, 24'hFFFFFF));
        repeat (3) ray_words.push_back(step_word());
        // position outside its start cell
        ray_words.push_back(start_word(24'h03ABCD, 24'hC81234, 8'd10, 8'd10, 1'b1, 1'b0,
                                       24'h00C000, 24'h018000));
        repeat (2) ray_words.push_back(step_word());
        // zero delta on x runs x to the edge
        ray_words.push_back(start_word(24'hFD8000, 24'h078000, 8'd253, 8'd7, 1'b0, 1'b0,
                                       24'h000000, 24'h010000));
        repeat (4) ray_words.push_back(step_word());
        // largest position, inside its start cell
        ray_words.push_back(start_word(24'hFFFFFF, 24'h008000, 8'd255, 8'd0, 1'b0, 1'b1,
                                       24'h010000, 24'h7FFFFF));
        repeat (2) ray_words.push_back(step_word());

        while (ray_words.size() < RANDOM_WORDS + 25) begin
            if ($urandom_range(99) < 85) begin
                cx = pick_cell();
                cy = pick_cell();
                ray_words.push_back(start_word(pick_pos(cx), pick_pos(cy), cx, cy,
                                               1'($urandom_range(1)), 1'($urandom_range(1)),
                                               pick_delta(), pick_delta()));
                n_steps = $urandom_range(40);
                repeat (n_steps) ray_words.push_back(step_word());
            end else begin
                w      = step_word();
                w.func = dgrs_pkg::t_func'($urandom_range(1));
                ray_words.push_back(w);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (ray_words.size() != 0 || expected_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && expected_hits.size() == 0) begin
            $display("dda_grid_ray_stepper_top: match");
        end else begin
            $display("dda_grid_ray_stepper_top: mismatch");
        end
        $finish;
    end

endmodule
